/* rtl/core/hps_pkg.sv */
// Package for the host power sequencer: state, colour and command codes,
// plus the fixed field widths used by the interfaces and the top level.
// No dependencies.
package hps_pkg;

    localparam int CntW   = 16;
    localparam int KnobW  = 10;
    localparam int ByteW  = 8;
    localparam int StateW = 3;
    localparam int ColW   = 3;
    localparam int CmdW   = 2;
    localparam int NumKnobs = 3;
    localparam int CfgIdxW  = 1;

    // Sequencer state codes.
    localparam logic [StateW-1:0] ST_RESET    = 3'd0;
    localparam logic [StateW-1:0] ST_STANDBY  = 3'd1;
    localparam logic [StateW-1:0] ST_BOOTING  = 3'd2;
    localparam logic [StateW-1:0] ST_OPERATE  = 3'd3;
    localparam logic [StateW-1:0] ST_SHUTDOWN = 3'd4;
    localparam logic [StateW-1:0] ST_HOSTSTOP = 3'd5;

    // LED colour codes.
    localparam logic [ColW-1:0] COL_OFF    = 3'd0;
    localparam logic [ColW-1:0] COL_ORANGE = 3'd1;
    localparam logic [ColW-1:0] COL_WHITE  = 3'd2;
    localparam logic [ColW-1:0] COL_RED    = 3'd3;
    localparam logic [ColW-1:0] COL_VIOLET = 3'd4;
    localparam logic [ColW-1:0] COL_BLUE   = 3'd5;

    // Item commands.
    localparam logic [CmdW-1:0] CMD_TICK     = 2'd0;
    localparam logic [CmdW-1:0] CMD_WR_REQ   = 2'd1;
    localparam logic [CmdW-1:0] CMD_WR_DONE  = 2'd2;
    localparam logic [CmdW-1:0] CMD_RD_REQ   = 2'd3;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CFG_SHUTDOWN_TICKS = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_RESTART_TICKS  = 1'd1;

    // Bus register pointer codes.
    localparam logic [ByteW-1:0] PTR_STATUS = 8'd0;
    localparam logic [ByteW-1:0] PTR_TUNE   = 8'd1;
    localparam logic [ByteW-1:0] PTR_BAND   = 8'd2;
    localparam logic [ByteW-1:0] PTR_VOLUME = 8'd3;

    // Heartbeat level toggles once every five ticks: count 0..4.
    localparam logic [2:0] BEAT_LAST = 3'd4;

    localparam logic [CntW-1:0] CNT_MAX = '1;

endpackage

/* rtl/core/hps_item_if.sv */
// Input channel of the host power sequencer: valid/ready plus the item fields.
// Depends on hps_pkg.
interface hps_item_if
    import hps_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CmdW-1:0]  cmd;
    logic             host_running;
    logic             ac_sample;
    logic [KnobW-1:0] tune_level;
    logic [KnobW-1:0] band_level;
    logic [KnobW-1:0] volume_level;
    logic [ByteW-1:0] bus_byte;

    modport source (
        output valid, cmd, host_running, ac_sample,
               tune_level, band_level, volume_level, bus_byte,
        input  ready
    );

    modport sink (
        input  valid, cmd, host_running, ac_sample,
               tune_level, band_level, volume_level, bus_byte,
        output ready
    );
endinterface

/* rtl/core/hps_result_if.sv */
// Output channel of the host power sequencer: valid/ready plus the result fields.
// Depends on hps_pkg.
interface hps_result_if
    import hps_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             supply_on;
    logic             run_request;
    logic [ColW-1:0]  led_code;
    logic             led_update;
    logic             heartbeat;
    logic [ByteW-1:0] status_byte;
    logic [ByteW-1:0] read_data;
    logic             read_valid;

    modport source (
        output valid, supply_on, run_request, led_code, led_update,
               heartbeat, status_byte, read_data, read_valid,
        input  ready
    );

    modport sink (
        input  valid, supply_on, run_request, led_code, led_update,
               heartbeat, status_byte, read_data, read_valid,
        output ready
    );
endinterface

/* rtl/core/host_power_sequencer.sv */
// Host power sequencer top level: six-state supply sequencer, LED colour and
// heartbeat generation, and a register-read bus slave.
// Depends on hps_pkg, hps_item_if and hps_result_if.
// Usage. Items arrive on the "items" channel; each one is either a tick
// (one pass of the sequencer, knob capture, heartbeat and status rebuild)
// or a bus event (write request, write completed, read request). Every
// accepted item produces exactly one result on the "results" channel.
//
// Latency and throughput. The state update and the result are computed in a
// single pass of logic from the transfer and land in the state and result
// registers at the same edge, so the result is valid in the cycle after the
// transfer. One item per cycle is sustained while the receiver takes results.
//
// Stalls. items.ready is high while the result register is empty or being
// transferred in the same cycle; a stalled receiver holds the result steady
// and backs up the input after one item.
//
// Reset. rst_n clears the state, loads the default shutdown and restart
// windows and empties the result register. Configuration writes land at the
// next edge and are meant to be issued while no result is pending.
module host_power_sequencer
    import hps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CntW-1:0]     cfg_data,
    hps_item_if.sink            items,
    hps_result_if.source        results
);

    // Configuration registers.
    logic [CntW-1:0]   shutdown_ticks_reg;
    logic [CntW-1:0]   restart_ticks_reg;

    // Sequencer state.
    logic [StateW-1:0] fsm_state_reg,     fsm_state_next;
    logic [StateW-1:0] entered_state_reg, entered_state_next;
    logic [CntW-1:0]   tick_count_reg,    tick_count_next;
    logic [CntW-1:0]   stopped_ticks_reg, stopped_ticks_next;
    logic              ac_flag_reg,       ac_flag_next;
    logic              running_flag_reg,  running_flag_next;
    logic              supply_level_reg,  supply_level_next;
    logic              request_level_reg, request_level_next;
    logic [ColW-1:0]   colour_now_reg,    colour_now_next;
    logic [ColW-1:0]   colour_sent_reg,   colour_sent_next;
    logic [2:0]        beat_count_reg,    beat_count_next;
    logic              beat_level_reg,    beat_level_next;
    logic [ByteW-1:0]  status_reg,        status_next;
    logic [KnobW-1:0]  knob_reg [NumKnobs];
    logic [ByteW-1:0]  reg_pointer_reg,   reg_pointer_next;
    logic              expect_address_reg, expect_address_next;
    logic [ByteW-1:0]  read_buffer_reg,   read_buffer_next;

    // Per-item flags and the result register.
    logic              led_update_next;
    logic              read_valid_next;
    logic              out_valid_reg;
    logic              led_update_reg;
    logic              read_valid_reg;

    logic              accept;
    logic              is_tick;

    assign items.ready = !out_valid_reg || results.ready;
    assign accept      = items.valid && items.ready;
    assign is_tick     = (items.cmd == CMD_TICK);

    // Sequencer pass for a tick item. Bus items leave all of this untouched.
    always_comb
    begin
        logic [CntW-1:0] tc;
        logic [CntW-1:0] stp;
        logic            run;
        logic            ac;

        tc  = (tick_count_reg == CNT_MAX) ? tick_count_reg : tick_count_reg + 1'b1;
        run = items.host_running;
        if (run)
        begin
            stp = '0;
        end
        else
        begin
            stp = (stopped_ticks_reg == CNT_MAX) ? stopped_ticks_reg
                                                 : stopped_ticks_reg + 1'b1;
        end
        ac = ac_flag_reg;

        fsm_state_next     = fsm_state_reg;
        entered_state_next = entered_state_reg;
        supply_level_next  = supply_level_reg;
        request_level_next = request_level_reg;
        colour_now_next    = colour_now_reg;
        colour_sent_next   = colour_sent_reg;
        beat_level_next    = beat_level_reg;

        // Entering a new state restarts the state counter; standby also
        // restarts the stopped counter.
        if (fsm_state_reg != ST_RESET && fsm_state_reg <= ST_HOSTSTOP &&
            entered_state_reg != fsm_state_reg)
        begin
            tc = '0;
            if (fsm_state_reg == ST_STANDBY)
            begin
                stp = '0;
            end
            entered_state_next = fsm_state_reg;
        end

        unique case (fsm_state_reg)
            ST_STANDBY:
            begin
                supply_level_next  = 1'b0;
                request_level_next = 1'b0;
                colour_now_next    = COL_OFF;
                fsm_state_next     = ac ? ST_BOOTING : ST_STANDBY;
            end
            ST_BOOTING:
            begin
                colour_now_next    = COL_ORANGE;
                supply_level_next  = 1'b1;
                request_level_next = 1'b1;
                if (run)
                begin
                    fsm_state_next = ST_OPERATE;
                end
                else if (!ac)
                begin
                    fsm_state_next = ST_STANDBY;
                end
            end
            ST_OPERATE:
            begin
                colour_now_next    = COL_WHITE;
                supply_level_next  = 1'b1;
                request_level_next = ac;
                if (!run)
                begin
                    fsm_state_next = ST_HOSTSTOP;
                end
                else if (!ac)
                begin
                    fsm_state_next = ST_SHUTDOWN;
                end
            end
            ST_SHUTDOWN:
            begin
                colour_now_next    = COL_RED;
                supply_level_next  = 1'b1;
                request_level_next = 1'b0;
                if (stp > shutdown_ticks_reg)
                begin
                    fsm_state_next = ST_STANDBY;
                end
            end
            ST_HOSTSTOP:
            begin
                colour_now_next   = COL_VIOLET;
                supply_level_next = 1'b1;
                if (tc > restart_ticks_reg && !run)
                begin
                    fsm_state_next = ST_STANDBY;
                end
                else if (tc < restart_ticks_reg && run)
                begin
                    fsm_state_next = ST_OPERATE;
                end
            end
            ST_RESET:
            begin
                fsm_state_next     = ST_STANDBY;
                entered_state_next = ST_RESET;
                tc                 = '0;
                stp                = '0;
                colour_now_next    = COL_BLUE;
                colour_sent_next   = COL_OFF;
                supply_level_next  = 1'b0;
                request_level_next = 1'b1;
                beat_level_next    = 1'b0;
            end
            default:
            begin
                // Undefined state codes hold; only the common steps run.
            end
        endcase

        tick_count_next    = tc;
        stopped_ticks_next = stp;
        running_flag_next  = run;

        led_update_next  = (colour_sent_next != colour_now_next);
        colour_sent_next = colour_now_next;

        if (beat_count_reg >= BEAT_LAST)
        begin
            beat_level_next = !beat_level_next;
            beat_count_next = '0;
        end
        else
        begin
            beat_count_next = beat_count_reg + 1'b1;
        end

        // The sample of this tick is used by the sequencer on the next tick.
        ac_flag_next = items.ac_sample;
        status_next  = {ac_flag_next, supply_level_next, run, request_level_next,
                        1'b0, fsm_state_next};
    end

    // Register-read bus slave.
    always_comb
    begin
        logic [ByteW-1:0] ptr_wrap;

        ptr_wrap            = {{(ByteW-2){1'b0}}, reg_pointer_reg[1:0] + 2'd1};
        reg_pointer_next    = reg_pointer_reg;
        expect_address_next = expect_address_reg;
        read_buffer_next    = read_buffer_reg;
        read_valid_next     = 1'b0;

        unique case (items.cmd)
            CMD_WR_REQ:
            begin
                expect_address_next = 1'b1;
            end
            CMD_WR_DONE:
            begin
                reg_pointer_next    = expect_address_reg ? items.bus_byte : ptr_wrap;
                expect_address_next = 1'b0;
            end
            CMD_RD_REQ:
            begin
                read_valid_next = 1'b1;
                case (reg_pointer_reg)
                    PTR_STATUS: read_buffer_next = status_reg;
                    PTR_TUNE:   read_buffer_next = knob_reg[0][ByteW-1:0];
                    PTR_BAND:   read_buffer_next = knob_reg[1][ByteW-1:0];
                    PTR_VOLUME: read_buffer_next = knob_reg[2][ByteW-1:0];
                    default:    read_buffer_next = read_buffer_reg;
                endcase
                reg_pointer_next = ptr_wrap;
            end
            default:
            begin
                // Ticks are handled by the sequencer pass.
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shutdown_ticks_reg <= CntW'(50);
            restart_ticks_reg  <= CntW'(100);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SHUTDOWN_TICKS: shutdown_ticks_reg <= cfg_data;
                CFG_RESTART_TICKS:  restart_ticks_reg  <= cfg_data;
                default:            ;
            endcase
        end
    end

    // State update on every transfer; the sequencer registers move on ticks only.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_state_reg      <= ST_RESET;
            entered_state_reg  <= ST_RESET;
            tick_count_reg     <= '0;
            stopped_ticks_reg  <= '0;
            ac_flag_reg        <= 1'b0;
            running_flag_reg   <= 1'b0;
            supply_level_reg   <= 1'b0;
            request_level_reg  <= 1'b0;
            colour_now_reg     <= COL_OFF;
            colour_sent_reg    <= COL_OFF;
            beat_count_reg     <= '0;
            beat_level_reg     <= 1'b0;
            status_reg         <= '0;
            knob_reg[0]        <= '0;
            knob_reg[1]        <= '0;
            knob_reg[2]        <= '0;
            reg_pointer_reg    <= '0;
            expect_address_reg <= 1'b0;
            read_buffer_reg    <= '0;
        end
        else if (accept)
        begin
            if (is_tick)
            begin
                fsm_state_reg     <= fsm_state_next;
                entered_state_reg <= entered_state_next;
                tick_count_reg    <= tick_count_next;
                stopped_ticks_reg <= stopped_ticks_next;
                ac_flag_reg       <= ac_flag_next;
                running_flag_reg  <= running_flag_next;
                supply_level_reg  <= supply_level_next;
                request_level_reg <= request_level_next;
                colour_now_reg    <= colour_now_next;
                colour_sent_reg   <= colour_sent_next;
                beat_count_reg    <= beat_count_next;
                beat_level_reg    <= beat_level_next;
                status_reg        <= status_next;
                knob_reg[0]       <= items.tune_level;
                knob_reg[1]       <= items.band_level;
                knob_reg[2]       <= items.volume_level;
            end
            reg_pointer_reg    <= reg_pointer_next;
            expect_address_reg <= expect_address_next;
            read_buffer_reg    <= read_buffer_next;
        end
    end

    // Result register. The level outputs come straight from the state
    // registers, which only move when a new result is loaded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            led_update_reg <= 1'b0;
            read_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg  <= 1'b1;
            led_update_reg <= is_tick && led_update_next;
            read_valid_reg <= read_valid_next;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.supply_on   = supply_level_reg;
    assign results.run_request = request_level_reg;
    assign results.led_code    = colour_now_reg;
    assign results.led_update  = led_update_reg;
    assign results.heartbeat   = beat_level_reg;
    assign results.status_byte = status_reg;
    assign results.read_data   = read_buffer_reg;
    assign results.read_valid  = read_valid_reg;

    // A tick taken in the reset state always moves the sequencer to standby.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_tick && fsm_state_reg == ST_RESET) |=> fsm_state_reg == ST_STANDBY)
        else $error("reset state did not advance to standby");

    // The read flag of a result matches the command of the item behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (results.valid &&
                    (results.read_valid == ($past(items.cmd) == CMD_RD_REQ))))
        else $error("result read flag does not match its item");

    // A colour change report always names the colour now recorded as sent.
    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.led_update) |-> colour_sent_reg == results.led_code)
        else $error("LED update flag disagrees with the sent colour");

    // The heartbeat divider never runs past its last count.
    assert property (@(posedge clk) disable iff (!rst_n)
        beat_count_reg <= BEAT_LAST)
        else $error("heartbeat divider out of range");

    // The status byte carries the host-running level of the last tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        status_reg[5] == running_flag_reg)
        else $error("status running bit disagrees with the running flag");

endmodule
